[rtl/rtfsm_pkg.sv]
`timescale 1ns / 1ps

package rtfsm_pkg;

    localparam int BYTE_W    = 8;
    localparam int CODE_W    = 48;
    localparam int COUNT_W   = 4;
    localparam int IDX_W     = 2;
    localparam int HIT_W     = 3;
    localparam int MAX_STATIONS = 4;
    localparam int PADDR_W   = 5;
    localparam int PDATA_W   = 64;

    localparam logic [BYTE_W-1:0]  STX_BYTE = 8'h02;
    localparam logic [BYTE_W-1:0]  ETX_BYTE = 8'h03;
    localparam logic [COUNT_W-1:0] TAG_LEN  = 4'd12;

    // Reset values of the station code registers, station 0 in the low slot.
    localparam logic [MAX_STATIONS-1:0][CODE_W-1:0] RESET_CODES = {
        48'h82003CA1D6C9,
        48'h82003C7EEC2C,
        48'h82003CE0530D,
        48'h4500B8D1FBD7
    };

    typedef enum logic {
        ST_IDLE,
        ST_COLLECT
    } rtfsm_state_t;

    // One classified request handed from the parser to the matcher.
    typedef struct packed {
        logic              close_hit;
        logic [CODE_W-1:0] tag;
    } rtfsm_entry_t;

    // Queue status seen by the producer and the consumer.
    typedef struct packed {
        logic full;
        logic empty;
    } rtfsm_qstat_t;

    // Returns {is_hex, nibble} for an uppercase hex character.
    function automatic logic [4:0] hex_decode(input logic [BYTE_W-1:0] c);
        logic [4:0] res;
        res = 5'd0;
        if (c >= 8'h30 && c <= 8'h39)
        begin
            res = {1'b1, c[3:0]};
        end
        else if (c >= 8'h41 && c <= 8'h46)
        begin
            res = {1'b1, c[3:0] + 4'd9};
        end
        return res;
    endfunction

endpackage

[rtl/rtfsm_front.sv]
`timescale 1ns / 1ps

module rtfsm_front
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          accept,
    input  logic [rtfsm_pkg::BYTE_W-1:0]  rx_byte,
    output rtfsm_pkg::rtfsm_entry_t       entry
);

    rtfsm_pkg::rtfsm_state_t state_reg, state_next;
    logic [rtfsm_pkg::COUNT_W-1:0] count_reg, count_next;
    logic [rtfsm_pkg::CODE_W-1:0]  tag_reg, tag_next;
    logic                          all_hex_reg, all_hex_next;
    logic [4:0]                    hex;
    logic                          take_char;
    logic                          full_tag;

    assign hex       = rtfsm_pkg::hex_decode(rx_byte);
    assign full_tag  = (count_reg >= rtfsm_pkg::TAG_LEN);
    assign take_char = (rx_byte != rtfsm_pkg::ETX_BYTE) && !full_tag;

    // Next state of the frame parser.
    always_comb
    begin
        state_next   = state_reg;
        count_next   = count_reg;
        tag_next     = tag_reg;
        all_hex_next = all_hex_reg;
        if (accept)
        begin
            case (state_reg)
                rtfsm_pkg::ST_IDLE:
                begin
                    if (rx_byte == rtfsm_pkg::STX_BYTE)
                    begin
                        state_next   = rtfsm_pkg::ST_COLLECT;
                        count_next   = '0;
                        all_hex_next = 1'b1;
                    end
                end
                rtfsm_pkg::ST_COLLECT:
                begin
                    if (take_char)
                    begin
                        tag_next   = {tag_reg[rtfsm_pkg::CODE_W-5:0], hex[3:0]};
                        count_next = count_reg + 1'b1;
                        if (!hex[4])
                        begin
                            all_hex_next = 1'b0;
                        end
                    end
                    else
                    begin
                        state_next = rtfsm_pkg::ST_IDLE;
                    end
                end
                default:
                begin
                    state_next = rtfsm_pkg::ST_IDLE;
                end
            endcase
        end
    end

    // Classification handed to the matcher: a close that may produce a hit.
    always_comb
    begin
        entry.tag = tag_reg;
        case (state_reg)
            rtfsm_pkg::ST_COLLECT: entry.close_hit = full_tag && all_hex_reg;
            default:               entry.close_hit = 1'b0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= rtfsm_pkg::ST_IDLE;
            count_reg   <= '0;
            all_hex_reg <= 1'b1;
        end
        else
        begin
            state_reg   <= state_next;
            count_reg   <= count_next;
            all_hex_reg <= all_hex_next;
        end
    end

    always_ff @(posedge clk)
    begin
        tag_reg <= tag_next;
    end

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= rtfsm_pkg::TAG_LEN)
        else $error("character count beyond tag length");

endmodule

[rtl/rtfsm_queue.sv]
`timescale 1ns / 1ps

module rtfsm_queue
(
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    push,
    input  rtfsm_pkg::rtfsm_entry_t push_data,
    input  logic                    pop,
    output rtfsm_pkg::rtfsm_entry_t head,
    output rtfsm_pkg::rtfsm_qstat_t stat
);

    rtfsm_pkg::rtfsm_entry_t mem_reg [2];
    logic       wr_ptr_reg, wr_ptr_next;
    logic       rd_ptr_reg, rd_ptr_next;
    logic [1:0] count_reg, count_next;

    assign stat.full  = (count_reg == 2'd2);
    assign stat.empty = (count_reg == 2'd0);
    assign head       = mem_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg ^ push;
        rd_ptr_next = rd_ptr_reg ^ pop;
        count_next  = count_reg + {1'b0, push} - {1'b0, pop};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem_reg[wr_ptr_reg] <= push_data;
        end
    end

    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        push |-> (!stat.full || pop))
        else $error("push into a full queue");

    a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
        pop |-> !stat.empty)
        else $error("pop from an empty queue");

endmodule

[rtl/rtfsm_back.sv]
`timescale 1ns / 1ps

module rtfsm_back
#(
    parameter int STATION_COUNT = 4
)
(
    input  logic                                              clk,
    input  logic                                              rst_n,
    input  logic [STATION_COUNT-1:0][rtfsm_pkg::CODE_W-1:0]   codes,
    input  rtfsm_pkg::rtfsm_entry_t                           head,
    input  rtfsm_pkg::rtfsm_qstat_t                           stat,
    output logic                                              pop,
    output logic                                              out_valid,
    input  logic                                              out_stall,
    output logic [rtfsm_pkg::HIT_W-1:0]                       station_hit,
    output logic                                              heading
);

    logic                          valid_reg, valid_next;
    logic [rtfsm_pkg::HIT_W-1:0]   hit_reg, hit_next;
    logic                          last_valid_reg, last_valid_next;
    logic [rtfsm_pkg::IDX_W-1:0]   last_idx_reg, last_idx_next;
    logic [rtfsm_pkg::IDX_W-1:0]   prev_reg, prev_next;
    logic                          dir_reg, dir_next;
    logic                          found;
    logic [rtfsm_pkg::IDX_W-1:0]   found_idx;

    assign pop = !stat.empty && (!valid_reg || !out_stall);

    // Parallel compare against every station but the last one reported, lowest index wins.
    always_comb
    begin
        found     = 1'b0;
        found_idx = '0;
        for (int i = STATION_COUNT - 1; i >= 0; i--)
        begin
            if (head.tag == codes[i] &&
                !(last_valid_reg && last_idx_reg == rtfsm_pkg::IDX_W'(i)))
            begin
                found     = 1'b1;
                found_idx = rtfsm_pkg::IDX_W'(i);
            end
        end
    end

    always_comb
    begin
        valid_next      = valid_reg;
        hit_next        = hit_reg;
        last_valid_next = last_valid_reg;
        last_idx_next   = last_idx_reg;
        prev_next       = prev_reg;
        dir_next        = dir_reg;
        if (pop)
        begin
            valid_next = 1'b1;
            hit_next   = '0;
            if (head.close_hit && found)
            begin
                hit_next        = {1'b0, found_idx} + 1'b1;
                last_valid_next = 1'b1;
                last_idx_next   = found_idx;
                prev_next       = found_idx;
                dir_next        = (found_idx > prev_reg) ? 1'b0 : 1'b1;
            end
        end
        else if (!out_stall)
        begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg      <= 1'b0;
            last_valid_reg <= 1'b0;
            last_idx_reg   <= '0;
            prev_reg       <= '0;
            dir_reg        <= 1'b0;
        end
        else
        begin
            valid_reg      <= valid_next;
            last_valid_reg <= last_valid_next;
            last_idx_reg   <= last_idx_next;
            prev_reg       <= prev_next;
            dir_reg        <= dir_next;
        end
    end

    always_ff @(posedge clk)
    begin
        hit_reg <= hit_next;
    end

    assign out_valid   = valid_reg;
    assign station_hit = hit_reg;
    assign heading     = dir_reg;

    a_hit_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        valid_reg |-> (hit_reg <= rtfsm_pkg::HIT_W'(STATION_COUNT)))
        else $error("reported station beyond station count");

    a_hit_records_last: assert property (@(posedge clk) disable iff (!rst_n)
        (pop && head.close_hit && found) |=>
            (last_valid_reg && hit_reg == {1'b0, last_idx_reg} + 1'b1))
        else $error("report not recorded as last matched station");

endmodule

[rtl/rfid_tag_frame_station_match.sv]
`timescale 1ns / 1ps
// A result is registered in the queue and then in the output register after its byte is accepted.
// One byte per cycle while the queue has room; the parser and the matcher are separated by a
// two-entry queue, so either side may stall without stopping the other until the queue fills or runs empty.
// Reset (rst_n low, asynchronous): parser idle waiting for STX, no station matched,
// direction away from base, station codes back to their default tags.

module rfid_tag_frame_station_match
#(
    parameter int STATION_COUNT = 4
)
(
    input  logic                                clk,
    input  logic                                rst_n,
    // Byte channel from the tag reader.
    input  logic                                in_valid,
    output logic                                in_stall,
    input  logic [rtfsm_pkg::BYTE_W-1:0]        rx_byte,
    // Result channel: one request out for every byte in.
    output logic                                out_valid,
    input  logic                                out_stall,
    output logic [rtfsm_pkg::HIT_W-1:0]         station_hit,
    output logic                                heading,
    // Configuration port.
    input  logic                                psel,
    input  logic                                penable,
    input  logic                                pwrite,
    input  logic [rtfsm_pkg::PADDR_W-1:0]       paddr,
    input  logic [rtfsm_pkg::PDATA_W-1:0]       pwdata,
    output logic [rtfsm_pkg::PDATA_W-1:0]       prdata,
    output logic                                pready
);

    // Station code registers. Each is 48 bits, so registers sit on 8-byte
    // boundaries and paddr[4:3] selects the station. Writes to a station
    // beyond STATION_COUNT are dropped and read back as zero.
    logic [STATION_COUNT-1:0][rtfsm_pkg::CODE_W-1:0] codes_reg;
    logic [rtfsm_pkg::IDX_W-1:0]                     cfg_idx;
    logic                                            cfg_wr;

    rtfsm_pkg::rtfsm_entry_t entry;
    rtfsm_pkg::rtfsm_entry_t head;
    rtfsm_pkg::rtfsm_qstat_t stat;
    logic                    accept;
    logic                    pop;

    assign pready  = 1'b1;
    assign cfg_idx = paddr[4:3];
    assign cfg_wr  = psel && penable && pwrite;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < STATION_COUNT; i++)
            begin
                codes_reg[i] <= rtfsm_pkg::RESET_CODES[i];
            end
        end
        else
        begin
            for (int i = 0; i < STATION_COUNT; i++)
            begin
                if (cfg_wr && cfg_idx == rtfsm_pkg::IDX_W'(i))
                begin
                    codes_reg[i] <= pwdata[rtfsm_pkg::CODE_W-1:0];
                end
            end
        end
    end

    // Read data is returned combinationally during the access phase.
    always_comb
    begin
        prdata = '0;
        for (int i = 0; i < STATION_COUNT; i++)
        begin
            if (cfg_idx == rtfsm_pkg::IDX_W'(i))
            begin
                prdata = {{(rtfsm_pkg::PDATA_W - rtfsm_pkg::CODE_W){1'b0}}, codes_reg[i]};
            end
        end
    end

    // The parser takes a byte whenever the queue has room. Every accepted
    // byte becomes one queue entry, which keeps results one for one with bytes.
    assign in_stall = stat.full;
    assign accept   = in_valid && !in_stall;

    rtfsm_front u_front
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .accept  (accept),
        .rx_byte (rx_byte),
        .entry   (entry)
    );

    rtfsm_queue u_queue
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (accept),
        .push_data (entry),
        .pop       (pop),
        .head      (head),
        .stat      (stat)
    );

    // The matcher compares a closed tag against all stations at once and
    // keeps the direction and last-station history.
    rtfsm_back #(
        .STATION_COUNT (STATION_COUNT)
    ) u_back
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .codes       (codes_reg),
        .head        (head),
        .stat        (stat),
        .pop         (pop),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .station_hit (station_hit),
        .heading     (heading)
    );

endmodule

[verif/station_match_checker.sv]
`timescale 1ns / 1ps

module station_match_checker
#(
    parameter int STATION_COUNT = 4
)
(
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              in_valid,
    input  logic                              in_stall,
    input  logic [rtfsm_pkg::BYTE_W-1:0]      rx_byte,
    input  logic                              out_valid,
    input  logic                              out_stall,
    input  logic [rtfsm_pkg::HIT_W-1:0]       station_hit,
    input  logic                              heading,
    input  logic                              psel,
    input  logic                              penable,
    input  logic                              pwrite,
    input  logic                              pready,
    input  logic [rtfsm_pkg::PADDR_W-1:0]     paddr,
    input  logic [rtfsm_pkg::PDATA_W-1:0]     pwdata,
    output int                                fail_count,
    output int                                pending_cnt
);

    localparam int   REG_SHIFT   = 3;
    localparam logic DIR_AWAY    = 1'b0;
    localparam logic DIR_TOWARD  = 1'b1;

    typedef struct packed {
        logic [rtfsm_pkg::HIT_W-1:0] hit;
        logic                        heading;
    } hit_report_t;

    // Mirror of the block's parser and matcher state.
    rtfsm_pkg::rtfsm_state_t       parse_state;
    logic [rtfsm_pkg::COUNT_W-1:0] char_cnt;
    logic [rtfsm_pkg::CODE_W-1:0]  tag_acc;
    logic                          tag_all_hex;
    logic                          last_hit_valid;
    logic [rtfsm_pkg::IDX_W-1:0]   last_hit_idx;
    logic [rtfsm_pkg::IDX_W-1:0]   prev_station;
    logic                          travel_dir;
    logic [rtfsm_pkg::CODE_W-1:0]  station_codes [rtfsm_pkg::MAX_STATIONS];

    hit_report_t        pending_reports [$];
    hit_report_t        want;
    int unsigned        reg_idx;

    function automatic hit_report_t predict_byte(input logic [rtfsm_pkg::BYTE_W-1:0] b);
        hit_report_t      r;
        logic [3:0]       digit;
        logic             found;
        r.hit = '0;
        found = 1'b0;
        if (parse_state == rtfsm_pkg::ST_IDLE)
        begin
            if (b == rtfsm_pkg::STX_BYTE)
            begin
                parse_state = rtfsm_pkg::ST_COLLECT;
                char_cnt    = '0;
                tag_acc     = '0;
                tag_all_hex = 1'b1;
            end
        end
        else if (b != rtfsm_pkg::ETX_BYTE && char_cnt < rtfsm_pkg::TAG_LEN)
        begin
            if (b >= "0" && b <= "9")
            begin
                digit = 4'(b - "0");
            end
            else if (b >= "A" && b <= "F")
            begin
                digit = 4'(b - "A" + 8'd10);
            end
            else
            begin
                digit       = 4'd0;
                tag_all_hex = 1'b0;
            end
            tag_acc  = {tag_acc[rtfsm_pkg::CODE_W-5:0], digit};
            char_cnt = char_cnt + 1'b1;
        end
        else if (char_cnt >= rtfsm_pkg::TAG_LEN)
        begin
            // First station that equals the tag and is not the last one reported.
            if (tag_all_hex)
            begin
                for (int s = 0; s < STATION_COUNT && s < rtfsm_pkg::MAX_STATIONS; s++)
                begin
                    if (!found && tag_acc == station_codes[s]
                        && !(last_hit_valid && last_hit_idx == rtfsm_pkg::IDX_W'(s)))
                    begin
                        found          = 1'b1;
                        last_hit_valid = 1'b1;
                        last_hit_idx   = rtfsm_pkg::IDX_W'(s);
                        travel_dir     = (rtfsm_pkg::IDX_W'(s) > prev_station)
                                         ? DIR_AWAY : DIR_TOWARD;
                        prev_station   = rtfsm_pkg::IDX_W'(s);
                        r.hit          = rtfsm_pkg::HIT_W'(s + 1);
                    end
                end
            end
            parse_state = rtfsm_pkg::ST_IDLE;
        end
        else
        begin
            parse_state = rtfsm_pkg::ST_IDLE;
        end
        r.heading = travel_dir;
        return r;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            parse_state    = rtfsm_pkg::ST_IDLE;
            char_cnt       = '0;
            tag_acc        = '0;
            tag_all_hex    = 1'b1;
            last_hit_valid = 1'b0;
            last_hit_idx   = '0;
            prev_station   = '0;
            travel_dir     = DIR_AWAY;
            for (int i = 0; i < rtfsm_pkg::MAX_STATIONS; i++)
            begin
                station_codes[i] = rtfsm_pkg::RESET_CODES[i];
            end
            pending_reports.delete();
        end
        else
        begin
            if (psel && penable && pwrite && pready)
            begin
                reg_idx = paddr >> REG_SHIFT;
                if (reg_idx < rtfsm_pkg::MAX_STATIONS)
                begin
                    station_codes[reg_idx] = pwdata[rtfsm_pkg::CODE_W-1:0];
                end
            end
            // Results leave before this edge's byte is predicted.
            if (out_valid && !out_stall)
            begin
                if (pending_reports.size() == 0)
                begin
                    $display("%0t: unexpected result hit=%0d heading=%0b",
                             $time, station_hit, heading);
                    fail_count++;
                end
                else
                begin
                    want = pending_reports.pop_front();
                    if (station_hit !== want.hit)
                    begin
                        $display("%0t: station_hit expected %0d, got %0d",
                                 $time, want.hit, station_hit);
                        fail_count++;
                    end
                    if (heading !== want.heading)
                    begin
                        $display("%0t: heading expected %0b, got %0b",
                                 $time, want.heading, heading);
                        fail_count++;
                    end
                end
            end
            if (in_valid && !in_stall)
            begin
                pending_reports.push_back(predict_byte(rx_byte));
            end
        end
        pending_cnt = pending_reports.size();
    end

endmodule

[verif/tb.sv]
`timescale 1ns / 1ps

// Top of the station matcher bench. It resets the block once, programs the
// station code registers between phases, and streams serial bytes shaped as
// tag frames. All checking lives in the checker; this module only decides
// what to send and reports the verdict.
module tb;

    localparam int CLK_HALF        = 4;
    localparam int RESET_CYCLES    = 3;
    localparam int ITEMS_PER_PHASE = 250;
    localparam int SETTLE_CYCLES   = 4;
    localparam int NO_BAD_POS      = 12;
    localparam int REG_SHIFT       = 3;
    localparam logic [rtfsm_pkg::CODE_W-1:0] CODE_ZERO = '0;
    localparam logic [rtfsm_pkg::CODE_W-1:0] CODE_ONES = '1;

    logic                          clk       = 1'b0;
    logic                          rst_n     = 1'b0;
    logic                          in_valid  = 1'b0;
    logic                          in_stall;
    logic [rtfsm_pkg::BYTE_W-1:0]  rx_byte   = '0;
    logic                          out_valid;
    logic                          out_stall = 1'b0;
    logic [rtfsm_pkg::HIT_W-1:0]   station_hit;
    logic                          heading;
    logic                          psel      = 1'b0;
    logic                          penable   = 1'b0;
    logic                          pwrite    = 1'b0;
    logic [rtfsm_pkg::PADDR_W-1:0] paddr     = '0;
    logic [rtfsm_pkg::PDATA_W-1:0] pwdata    = '0;
    logic [rtfsm_pkg::PDATA_W-1:0] prdata;
    logic                          pready;

    int fail_count;
    int pending_cnt;

    // Chance, in percent, that the reader leaves a cycle empty before a byte,
    // and that the result side holds off a cycle.
    int send_idle_pct  = 0;
    int recv_stall_pct = 0;
    int phase_items;

    // The codes currently programmed, so that frames can be aimed at them.
    logic [rtfsm_pkg::CODE_W-1:0] code_now [rtfsm_pkg::MAX_STATIONS];

    rfid_tag_frame_station_match #(
        .STATION_COUNT(rtfsm_pkg::MAX_STATIONS)
    ) u_dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_stall   (in_stall),
        .rx_byte    (rx_byte),
        .out_valid  (out_valid),
        .out_stall  (out_stall),
        .station_hit(station_hit),
        .heading    (heading),
        .psel       (psel),
        .penable    (penable),
        .pwrite     (pwrite),
        .paddr      (paddr),
        .pwdata     (pwdata),
        .prdata     (prdata),
        .pready     (pready)
    );

    station_match_checker #(
        .STATION_COUNT(rtfsm_pkg::MAX_STATIONS)
    ) u_checker (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_stall   (in_stall),
        .rx_byte    (rx_byte),
        .out_valid  (out_valid),
        .out_stall  (out_stall),
        .station_hit(station_hit),
        .heading    (heading),
        .psel       (psel),
        .penable    (penable),
        .pwrite     (pwrite),
        .pready     (pready),
        .paddr      (paddr),
        .pwdata     (pwdata),
        .fail_count (fail_count),
        .pending_cnt(pending_cnt)
    );

    always #CLK_HALF clk = ~clk;

    // The result side stalls at random; the rate changes from phase to phase.
    always @(posedge clk)
    begin
        out_stall <= ($urandom_range(99) < recv_stall_pct);
    end

    // Uppercase hex character for one packed digit.
    function automatic logic [rtfsm_pkg::BYTE_W-1:0] hex_char(input logic [3:0] n);
        return (n < 4'd10) ? "0" + rtfsm_pkg::BYTE_W'(n)
                           : "A" - 8'd10 + rtfsm_pkg::BYTE_W'(n);
    endfunction

    // One byte request. An optional run of empty cycles comes first; the byte
    // then stays on the port until the block takes it. The valid is left high
    // on return so that back-to-back bytes never drop it within a time step.
    task automatic send_byte(input logic [rtfsm_pkg::BYTE_W-1:0] b);
        while ($urandom_range(99) < send_idle_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        rx_byte  <= b;
        do
        begin
            @(posedge clk);
        end
        while (in_stall);
    endtask

    // Drop the byte stream and wait until every result is out, so that the
    // block is idle before the registers change or the run ends.
    task automatic drain();
        in_valid <= 1'b0;
        @(posedge clk);
        wait (pending_cnt == 0);
    endtask

    // Register write: setup cycle, then access cycle until pready.
    task automatic write_code(input int idx, input logic [rtfsm_pkg::CODE_W-1:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= rtfsm_pkg::PADDR_W'(idx << REG_SHIFT);
        pwdata  <= rtfsm_pkg::PDATA_W'(value);
        @(posedge clk);
        penable <= 1'b1;
        do
        begin
            @(posedge clk);
        end
        while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(posedge clk);
        code_now[idx] = value;
    endtask

    // A full frame: STX, twelve characters, then the byte that closes it.
    // The character at bad_pos, if any, is replaced by bad_char.
    task automatic send_tag(input logic [rtfsm_pkg::CODE_W-1:0] tag, input int bad_pos,
                            input logic [rtfsm_pkg::BYTE_W-1:0] bad_char,
                            input logic [rtfsm_pkg::BYTE_W-1:0] closer);
        send_byte(rtfsm_pkg::STX_BYTE);
        for (int i = 0; i < 12; i++)
        begin
            if (i == bad_pos)
            begin
                send_byte(bad_char);
            end
            else
            begin
                send_byte(hex_char(tag[rtfsm_pkg::CODE_W-1-4*i -: 4]));
            end
        end
        send_byte(closer);
    endtask

    // One random stretch of traffic. Most of it is well-formed frames aimed at
    // the programmed stations, so that matches, repeats and direction changes
    // happen often; the rest is random tags, frames with a non-hex character,
    // frames cut short by ETX, and line noise.
    task automatic send_random_frame();
        int                           kind;
        int                           pick;
        int                           n_chars;
        logic [rtfsm_pkg::BYTE_W-1:0] closer;
        logic [rtfsm_pkg::BYTE_W-1:0] bad;
        logic [rtfsm_pkg::CODE_W-1:0] tag;
        kind = $urandom_range(99);
        pick = $urandom_range(9);
        closer = (pick == 0) ? rtfsm_pkg::STX_BYTE
               : (pick == 1) ? rtfsm_pkg::ETX_BYTE
               : rtfsm_pkg::BYTE_W'($urandom_range(255));
        if (kind < 60)
        begin
            tag = code_now[$urandom_range(rtfsm_pkg::MAX_STATIONS-1)];
            send_tag(tag, NO_BAD_POS, '0, closer);
            phase_items += 14;
        end
        else if (kind < 72)
        begin
            tag = rtfsm_pkg::CODE_W'({$urandom, $urandom});
            send_tag(tag, NO_BAD_POS, '0, closer);
            phase_items += 14;
        end
        else if (kind < 84)
        begin
            // A station tag spoiled by one character that is not uppercase hex:
            // lowercase, NUL, or any other byte except ETX.
            pick = $urandom_range(3);
            if (pick == 0)
            begin
                bad = "a" + rtfsm_pkg::BYTE_W'($urandom_range(5));
            end
            else if (pick == 1)
            begin
                bad = 8'h00;
            end
            else
            begin
                do
                begin
                    bad = rtfsm_pkg::BYTE_W'($urandom_range(255));
                end
                while ((bad >= "0" && bad <= "9") || (bad >= "A" && bad <= "F")
                       || bad == rtfsm_pkg::ETX_BYTE);
            end
            tag = code_now[$urandom_range(rtfsm_pkg::MAX_STATIONS-1)];
            send_tag(tag, $urandom_range(11), bad, closer);
            phase_items += 14;
        end
        else if (kind < 92)
        begin
            // ETX before the twelfth character aborts the frame.
            n_chars = $urandom_range(11);
            send_byte(rtfsm_pkg::STX_BYTE);
            for (int i = 0; i < n_chars; i++)
            begin
                send_byte(hex_char(4'($urandom_range(15))));
            end
            send_byte(rtfsm_pkg::ETX_BYTE);
            phase_items += n_chars + 2;
        end
        else
        begin
            // Noise on the line. Bytes outside a frame are mostly ignored, so
            // they do not count toward the phase; a stray STX here leaves the
            // next frame misaligned, which is a useful broken sequence.
            n_chars = $urandom_range(4, 1);
            for (int i = 0; i < n_chars; i++)
            begin
                send_byte(rtfsm_pkg::BYTE_W'($urandom_range(255)));
            end
        end
    endtask

    task automatic run_phase(input int idle_pct, input int stall_pct);
        send_idle_pct  = idle_pct;
        recv_stall_pct = stall_pct;
        phase_items    = 0;
        while (phase_items < ITEMS_PER_PHASE)
        begin
            send_random_frame();
        end
        drain();
    endtask

    // Run limit, far above the slowest legal run.
    initial
    begin
        #2_000_000;
        $display("tb NOT OK");
        $finish;
    end

    initial
    begin
        for (int i = 0; i < rtfsm_pkg::MAX_STATIONS; i++)
        begin
            code_now[i] = rtfsm_pkg::RESET_CODES[i];
        end
        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed part, on the reset codes and with no idling.
        // Bytes while idle are ignored, ETX among them.
        send_byte(8'h00);
        send_byte(8'hFF);
        send_byte(rtfsm_pkg::ETX_BYTE);
        // Station 1, closed by ETX: reported, heading away from base.
        send_tag(code_now[1], NO_BAD_POS, '0, rtfsm_pkg::ETX_BYTE);
        // Base station, closed by STX: reported, heading toward base. The STX
        // only closes the frame and does not open a new one.
        send_tag(code_now[0], NO_BAD_POS, '0, rtfsm_pkg::STX_BYTE);
        // ETX after one character aborts silently.
        send_byte(rtfsm_pkg::STX_BYTE);
        send_byte("F");
        send_byte(rtfsm_pkg::ETX_BYTE);
        // Station 1 again, but with a lowercase digit: no match.
        send_tag(code_now[1], 5, "d", 8'hFF);
        drain();

        // Extremes, and two stations sharing one code so that a repeat of the
        // first can still be reported as the second.
        write_code(0, CODE_ZERO);
        write_code(1, CODE_ZERO);
        write_code(2, CODE_ONES);
        write_code(3, rtfsm_pkg::CODE_W'({$urandom, $urandom}));
        run_phase(33, 84);

        write_code(0, rtfsm_pkg::CODE_W'({$urandom, $urandom}));
        write_code(1, CODE_ONES);
        write_code(2, CODE_ONES);
        write_code(3, CODE_ZERO);
        run_phase(84, 33);

        for (int i = 0; i < rtfsm_pkg::MAX_STATIONS; i++)
        begin
            write_code(i, rtfsm_pkg::RESET_CODES[i]);
        end
        run_phase(0, 0);

        repeat (SETTLE_CYCLES) @(posedge clk);
        if (fail_count == 0 && pending_cnt == 0)
        begin
            $display("tb OK");
        end
        else
        begin
            $display("tb NOT OK");
        end
        $finish;
    end

endmodule
